[hdl/lbmd2q9_pkg.sv]
// shared constants and register codes for the d2q9 bgk node update unit
package lbmd2q9_pkg;

    localparam int FRAC_BITS_DEF   = 20;
    localparam int VALUE_WIDTH_DEF = 24;

    localparam int RELAX_WIDTH     = 21;
    localparam int LID_WIDTH       = 20;
    localparam int CFG_DATA_WIDTH  = 21;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELAX_RATE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LID_VELOCITY = 2'd1;

    localparam logic [RELAX_WIDTH-1:0] RELAX_RESET = 21'd1826620;
    localparam logic [LID_WIDTH-1:0]   LID_RESET   = 20'd260833;

    localparam int NUM_DIR = 9;

    // lattice directions, index dx+1+3(dy+1)
    localparam int DIR_DX [NUM_DIR] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};
    localparam int DIR_DY [NUM_DIR] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};

    // weight class: 0 rest (4/9), 1 axis (1/9), 2 diagonal (1/36)
    localparam int NUM_WCLS = 3;
    localparam int DIR_WCLS [NUM_DIR] = '{2, 1, 2, 1, 0, 1, 2, 1, 2};

    localparam int DIV_STEPS = 4;

endpackage

[hdl/lbm_d2q9_bgk_node_update_unit.sv]
// d2q9 lattice boltzmann node update with bgk collision, deep pipeline
//
// Input channel in_valid/in_ready carries one lattice node per transfer: the nine
// streamed populations, the wall side mask, the lid flag and the density of the
// node below. Output channel out_valid/out_ready carries one result per node:
// nine post-collision populations, density and velocity. Results come out in
// input order.
// The node passes through a register pipeline of 14 + ceil(VALUE_WIDTH/4) stages;
// the two velocity dividers take VALUE_WIDTH restoring steps at four steps per
// stage and fill ceil(VALUE_WIDTH/4) of those stages with their steps.
// A new node is taken every cycle while the output is taken every cycle.
// When out_ready is low the last stage holds its result and earlier stages keep
// filling empty slots, so in_ready drops only once every stage is occupied.
// Configuration writes (relax rate, lid velocity) take effect at once and are to be
// made by the user while no node is in flight; the block does not enforce this.
// Reset clears all stage valid bits and loads the register reset values.
module lbm_d2q9_bgk_node_update_unit
    import lbmd2q9_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]         cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [VALUE_WIDTH-1:0]     pop_0,
    input  logic signed [VALUE_WIDTH-1:0]     pop_1,
    input  logic signed [VALUE_WIDTH-1:0]     pop_2,
    input  logic signed [VALUE_WIDTH-1:0]     pop_3,
    input  logic signed [VALUE_WIDTH-1:0]     pop_4,
    input  logic signed [VALUE_WIDTH-1:0]     pop_5,
    input  logic signed [VALUE_WIDTH-1:0]     pop_6,
    input  logic signed [VALUE_WIDTH-1:0]     pop_7,
    input  logic signed [VALUE_WIDTH-1:0]     pop_8,
    input  logic [2:0]                        wall_sides,
    input  logic                              is_lid,
    input  logic [VALUE_WIDTH-2:0]            neighbor_density,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_0,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_1,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_2,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_3,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_4,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_5,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_6,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_7,
    output logic signed [VALUE_WIDTH-1:0]     out_pop_8,
    output logic [VALUE_WIDTH-2:0]            node_density,
    output logic signed [VALUE_WIDTH-1:0]     vel_x,
    output logic signed [VALUE_WIDTH-1:0]     vel_y
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = (W + 2 > RELAX_WIDTH + 1) ? W + 2 : RELAX_WIDTH + 1;
    localparam int SW = W + 8;
    localparam int NW = W + 3;
    localparam int BW = NW + W;
    localparam int DIV_ST = (W + DIV_STEPS - 1) / DIV_STEPS;

    localparam int ST_L1  = 0;
    localparam int ST_L2  = 1;
    localparam int ST_L3  = 2;
    localparam int ST_L4  = 3;
    localparam int ST_SUM = 4;
    localparam int ST_DV0 = 5;
    localparam int ST_VEL = ST_DV0 + DIV_ST + 1;
    localparam int ST_E1  = ST_VEL + 1;
    localparam int ST_E2  = ST_VEL + 2;
    localparam int ST_E3  = ST_VEL + 3;
    localparam int ST_E4  = ST_VEL + 4;
    localparam int ST_E5  = ST_VEL + 5;
    localparam int ST_E6  = ST_VEL + 6;
    localparam int ST_OUT = ST_VEL + 7;
    localparam int NST    = ST_OUT + 1;

    localparam longint WGT_REST = ((longint'(4) << (F + 1)) + 9) / 18;
    localparam longint WGT_AXIS = ((longint'(1) << (F + 1)) + 9) / 18;
    localparam longint WGT_DIAG = ((longint'(1) << (F + 1)) + 36) / 72;

    localparam logic signed [MW-1:0] WGT [NUM_WCLS] =
        '{MW'(WGT_REST), MW'(WGT_AXIS), MW'(WGT_DIAG)};
    localparam logic signed [MW-1:0] C45   = MW'(longint'(9) << (F - 1));
    localparam logic signed [MW-1:0] C15   = MW'(longint'(3) << (F - 1));
    localparam logic signed [SW-1:0] ONE_S = SW'(longint'(1) << F);

    typedef logic [W-1:0]                val_t;
    typedef logic [W-2:0]                dens_t;
    typedef logic [NUM_DIR-1:0][W-1:0]   pops_t;
    typedef logic [NUM_WCLS-1:0][W-1:0]  wvals_t;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] nb;
        logic [W-1:0] quo;
        logic         neg;
        logic         ovf;
    } div_t;

    localparam val_t  VMAX_V = {1'b0, {(W-1){1'b1}}};
    localparam val_t  VMIN_V = {1'b1, {(W-1){1'b0}}};
    localparam dens_t VMAX_D = {(W-1){1'b1}};
    localparam logic signed [SW-1:0] SVMAX = SW'(VMAX_V);
    localparam logic signed [SW-1:0] SVMIN = -SVMAX - SW'(1);

    function automatic logic signed [MW-1:0] sxm(input val_t v);
        return MW'($signed(v));
    endfunction

    function automatic logic signed [SW-1:0] sxs(input val_t v);
        return SW'($signed(v));
    endfunction

    function automatic val_t sat(input logic signed [SW-1:0] v);
        if (v > SVMAX) return VMAX_V;
        if (v < SVMIN) return VMIN_V;
        return v[W-1:0];
    endfunction

    // product shifted by the fraction width, rounded half away from zero
    function automatic val_t fmul(input logic signed [MW-1:0] a,
                                  input logic signed [MW-1:0] b);
        logic            neg;
        logic [MW-1:0]   ua;
        logic [MW-1:0]   ub;
        logic [2*MW-1:0] p;
        logic [2*MW-1:0] r;
        neg = a[MW-1] ^ b[MW-1];
        ua  = a[MW-1] ? MW'(-a) : MW'(a);
        ub  = b[MW-1] ? MW'(-b) : MW'(b);
        p   = (2*MW)'(ua) * (2*MW)'(ub) + ((2*MW)'(1) << (F - 1));
        r   = p >> F;
        if (neg) begin
            if (r > (2*MW)'(VMAX_V) + (2*MW)'(1)) return VMIN_V;
            return W'((2*MW)'(0) - r);
        end
        if (r > (2*MW)'(VMAX_V)) return VMAX_V;
        return r[W-1:0];
    endfunction

    function automatic div_t div_setup(input logic signed [NW-1:0] m, input dens_t den);
        div_t                  o;
        logic [NW-1:0]         n;
        logic [NW+F:0]         sh;
        o.neg = m[NW-1];
        n     = m[NW-1] ? NW'(-m) : NW'(m);
        o.ovf = BW'(n) >= (BW'(den) << (W - 1 - F));
        sh    = (NW+F+1)'(n) << (F + 1);
        o.nb  = sh[W-1:0];
        o.rem = W'(n >> (W - F - 1));
        o.quo = '0;
        return o;
    endfunction

    function automatic div_t div_step(input div_t d, input dens_t den);
        div_t         o;
        logic [W-1:0] t;
        o    = d;
        t    = {d.rem[W-2:0], d.nb[W-1]};
        o.nb = {d.nb[W-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
            o.rem = t - {1'b0, den};
            o.quo = {d.quo[W-2:0], 1'b1};
        end else begin
            o.rem = t;
            o.quo = {d.quo[W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic val_t div_finish(input div_t d, input dens_t den);
        logic [W:0] r;
        if (den == '0) return '0;
        if (d.ovf) return d.neg ? VMIN_V : VMAX_V;
        r = ({1'b0, d.quo} + (W+1)'(1)) >> 1;
        if (d.neg) begin
            if (r > {1'b0, VMAX_V} + (W+1)'(1)) return VMIN_V;
            return W'((W+1)'(0) - r);
        end
        if (r > {1'b0, VMAX_V}) return VMAX_V;
        return r[W-1:0];
    endfunction

    // configuration registers
    logic [RELAX_WIDTH-1:0] relax_rate_reg;
    logic [LID_WIDTH-1:0]   lid_velocity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_rate_reg   <= RELAX_RESET;
            lid_velocity_reg <= LID_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_RELAX_RATE:   relax_rate_reg   <= cfg_data[RELAX_WIDTH-1:0];
                REG_LID_VELOCITY: lid_velocity_reg <= cfg_data[LID_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // stage valid bits and bubble-collapsing advance enables
    logic [NST-1:0] vld_reg;
    logic [NST:0]   en;

    assign en[NST] = out_ready;
    for (genvar k = 0; k < NST; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];

    // L1: bounce-back, lid velocity squares, lid weighted density
    pops_t  fb_next;
    val_t   lsq_next, leup_next, leum_next, leep_next, leem_next;
    wvals_t lwr_next;
    pops_t  l1_f_reg;
    logic   l1_lid_reg;
    val_t   lsq_reg, leup_reg, leum_reg, leep_reg, leem_reg;
    wvals_t l1_wr_reg;

    always_comb
    begin
        fb_next = {pop_8, pop_7, pop_6, pop_5, pop_4, pop_3, pop_2, pop_1, pop_0};
        // in place, in direction order, so a later copy sees an earlier one
        for (int i = 0; i < NUM_DIR; i++)
        begin
            if ((DIR_DX[i] < 0 && wall_sides[0]) || (DIR_DX[i] > 0 && wall_sides[1]) ||
                (DIR_DY[i] < 0 && wall_sides[2]))
                fb_next[NUM_DIR-1-i] = fb_next[i];
        end
        lsq_next  = fmul(MW'(lid_velocity_reg), MW'(lid_velocity_reg));
        leup_next = sat(SW'(lid_velocity_reg));
        leum_next = sat(SW'(0) - SW'(lid_velocity_reg));
        leep_next = fmul(sxm(leup_next), sxm(leup_next));
        leem_next = fmul(sxm(leum_next), sxm(leum_next));
        for (int c = 0; c < NUM_WCLS; c++)
            lwr_next[c] = fmul(WGT[c], MW'(neighbor_density));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_L1])
        begin
            l1_f_reg   <= fb_next;
            l1_lid_reg <= is_lid;
            lsq_reg    <= lsq_next;
            leup_reg   <= leup_next;
            leum_reg   <= leum_next;
            leep_reg   <= leep_next;
            leem_reg   <= leem_next;
            l1_wr_reg  <= lwr_next;
        end
    end

    // L2: lid quadratic terms
    pops_t  l2_f_reg;
    logic   l2_lid_reg;
    wvals_t l2_wr_reg;
    val_t   l2_eup_reg, l2_eum_reg, lq_reg, lhp_reg, lhm_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_L2])
        begin
            l2_f_reg   <= l1_f_reg;
            l2_lid_reg <= l1_lid_reg;
            l2_wr_reg  <= l1_wr_reg;
            l2_eup_reg <= leup_reg;
            l2_eum_reg <= leum_reg;
            lq_reg     <= fmul(C15, sxm(lsq_reg));
            lhp_reg    <= fmul(C45, sxm(leep_reg));
            lhm_reg    <= fmul(C45, sxm(leem_reg));
        end
    end

    // L3: lid brackets for rest/axis-free, +x and -x directions
    pops_t  l3_f_reg;
    logic   l3_lid_reg;
    wvals_t l3_wr_reg;
    val_t   lb0_reg, lbp_reg, lbm_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_L3])
        begin
            l3_f_reg   <= l2_f_reg;
            l3_lid_reg <= l2_lid_reg;
            l3_wr_reg  <= l2_wr_reg;
            lb0_reg    <= sat(ONE_S - sxs(lq_reg));
            lbp_reg    <= sat(ONE_S + (sxs(l2_eup_reg) <<< 1) + sxs(l2_eup_reg)
                              + sxs(lhp_reg) - sxs(lq_reg));
            lbm_reg    <= sat(ONE_S + (sxs(l2_eum_reg) <<< 1) + sxs(l2_eum_reg)
                              + sxs(lhm_reg) - sxs(lq_reg));
        end
    end

    // L4: lid equilibrium replaces the populations of lid nodes
    pops_t fsel_next;
    pops_t l4_f_reg;

    always_comb
    begin
        val_t b;
        for (int i = 0; i < NUM_DIR; i++)
        begin
            b = (DIR_DX[i] == 0) ? lb0_reg : ((DIR_DX[i] > 0) ? lbp_reg : lbm_reg);
            fsel_next[i] = l3_lid_reg ? fmul(sxm(l3_wr_reg[DIR_WCLS[i]]), sxm(b))
                                      : l3_f_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_L4]) l4_f_reg <= fsel_next;
    end

    // SUM: density and momentum sums
    logic signed [SW-1:0] sum_next, sum_reg;
    logic signed [NW-1:0] mx_next, my_next, mx_reg, my_reg;
    pops_t                s_f_reg;

    always_comb
    begin
        sum_next = '0;
        mx_next  = '0;
        my_next  = '0;
        for (int i = 0; i < NUM_DIR; i++)
        begin
            sum_next = sum_next + sxs(l4_f_reg[i]);
            if (DIR_DX[i] > 0) mx_next = mx_next + NW'($signed(l4_f_reg[i]));
            if (DIR_DX[i] < 0) mx_next = mx_next - NW'($signed(l4_f_reg[i]));
            if (DIR_DY[i] > 0) my_next = my_next + NW'($signed(l4_f_reg[i]));
            if (DIR_DY[i] < 0) my_next = my_next - NW'($signed(l4_f_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sum_reg <= sum_next;
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            s_f_reg <= l4_f_reg;
        end
    end

    // DV0 .. DV(DIV_ST): restoring dividers for both velocity components
    dens_t rho_next;
    div_t  dvx_reg [DIV_ST+1];
    div_t  dvy_reg [DIV_ST+1];
    dens_t dvr_reg [DIV_ST+1];
    pops_t dvf_reg [DIV_ST+1];

    assign rho_next = (sum_reg <= SW'(0)) ? '0 :
                      ((sum_reg > SVMAX) ? VMAX_D : sum_reg[W-2:0]);

    always_ff @(posedge clk)
    begin
        if (en[ST_DV0])
        begin
            dvx_reg[0] <= div_setup(mx_reg, rho_next);
            dvy_reg[0] <= div_setup(my_reg, rho_next);
            dvr_reg[0] <= rho_next;
            dvf_reg[0] <= s_f_reg;
        end
    end

    for (genvar j = 1; j <= DIV_ST; j++)
    begin : g_div
        div_t tx_next, ty_next;

        always_comb
        begin
            tx_next = dvx_reg[j-1];
            ty_next = dvy_reg[j-1];
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                if ((j - 1) * DIV_STEPS + s < W)
                begin
                    tx_next = div_step(tx_next, dvr_reg[j-1]);
                    ty_next = div_step(ty_next, dvr_reg[j-1]);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DV0+j])
            begin
                dvx_reg[j] <= tx_next;
                dvy_reg[j] <= ty_next;
                dvr_reg[j] <= dvr_reg[j-1];
                dvf_reg[j] <= dvf_reg[j-1];
            end
        end
    end

    // VEL: rounding and saturation of the quotients
    val_t  ux_reg, uy_reg;
    dens_t v_rho_reg;
    pops_t v_f_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_VEL])
        begin
            ux_reg    <= div_finish(dvx_reg[DIV_ST], dvr_reg[DIV_ST]);
            uy_reg    <= div_finish(dvy_reg[DIV_ST], dvr_reg[DIV_ST]);
            v_rho_reg <= dvr_reg[DIV_ST];
            v_f_reg   <= dvf_reg[DIV_ST];
        end
    end

    // E1: projected velocities, squares, weighted density
    pops_t                eu_next;
    pops_t                e1_eu_reg, e1_f_reg;
    val_t                 xx_reg, yy_reg, e1_ux_reg, e1_uy_reg;
    wvals_t               e1_wr_reg, wr_next;
    dens_t                e1_rho_reg;

    always_comb
    begin
        logic signed [SW-1:0] e;
        for (int i = 0; i < NUM_DIR; i++)
        begin
            e = '0;
            if (DIR_DX[i] > 0) e = e + sxs(ux_reg);
            if (DIR_DX[i] < 0) e = e - sxs(ux_reg);
            if (DIR_DY[i] > 0) e = e + sxs(uy_reg);
            if (DIR_DY[i] < 0) e = e - sxs(uy_reg);
            eu_next[i] = sat(e);
        end
        for (int c = 0; c < NUM_WCLS; c++)
            wr_next[c] = fmul(WGT[c], MW'(v_rho_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E1])
        begin
            e1_eu_reg  <= eu_next;
            xx_reg     <= fmul(sxm(ux_reg), sxm(ux_reg));
            yy_reg     <= fmul(sxm(uy_reg), sxm(uy_reg));
            e1_wr_reg  <= wr_next;
            e1_f_reg   <= v_f_reg;
            e1_rho_reg <= v_rho_reg;
            e1_ux_reg  <= ux_reg;
            e1_uy_reg  <= uy_reg;
        end
    end

    // E2: squared projections and the common quadratic term
    pops_t  ee_next;
    pops_t  e2_ee_reg, e2_eu_reg, e2_f_reg;
    val_t   e2_q_reg, e2_ux_reg, e2_uy_reg;
    wvals_t e2_wr_reg;
    dens_t  e2_rho_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIR; i++)
            ee_next[i] = fmul(sxm(e1_eu_reg[i]), sxm(e1_eu_reg[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E2])
        begin
            e2_ee_reg  <= ee_next;
            e2_q_reg   <= fmul(C15, sxm(xx_reg) + sxm(yy_reg));
            e2_eu_reg  <= e1_eu_reg;
            e2_wr_reg  <= e1_wr_reg;
            e2_f_reg   <= e1_f_reg;
            e2_rho_reg <= e1_rho_reg;
            e2_ux_reg  <= e1_ux_reg;
            e2_uy_reg  <= e1_uy_reg;
        end
    end

    // E3: scale by 4.5
    pops_t  h_next;
    pops_t  e3_h_reg, e3_eu_reg, e3_f_reg;
    val_t   e3_q_reg, e3_ux_reg, e3_uy_reg;
    wvals_t e3_wr_reg;
    dens_t  e3_rho_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIR; i++)
            h_next[i] = fmul(C45, sxm(e2_ee_reg[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E3])
        begin
            e3_h_reg   <= h_next;
            e3_q_reg   <= e2_q_reg;
            e3_eu_reg  <= e2_eu_reg;
            e3_wr_reg  <= e2_wr_reg;
            e3_f_reg   <= e2_f_reg;
            e3_rho_reg <= e2_rho_reg;
            e3_ux_reg  <= e2_ux_reg;
            e3_uy_reg  <= e2_uy_reg;
        end
    end

    // E4: brackets
    pops_t  br_next;
    pops_t  e4_br_reg, e4_f_reg;
    val_t   e4_ux_reg, e4_uy_reg;
    wvals_t e4_wr_reg;
    dens_t  e4_rho_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIR; i++)
            br_next[i] = sat(ONE_S + (sxs(e3_eu_reg[i]) <<< 1) + sxs(e3_eu_reg[i])
                             + sxs(e3_h_reg[i]) - sxs(e3_q_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E4])
        begin
            e4_br_reg  <= br_next;
            e4_wr_reg  <= e3_wr_reg;
            e4_f_reg   <= e3_f_reg;
            e4_rho_reg <= e3_rho_reg;
            e4_ux_reg  <= e3_ux_reg;
            e4_uy_reg  <= e3_uy_reg;
        end
    end

    // E5: equilibrium populations
    pops_t feq_next;
    pops_t e5_feq_reg, e5_f_reg;
    val_t  e5_ux_reg, e5_uy_reg;
    dens_t e5_rho_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIR; i++)
            feq_next[i] = fmul(sxm(e4_wr_reg[DIR_WCLS[i]]), sxm(e4_br_reg[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E5])
        begin
            e5_feq_reg <= feq_next;
            e5_f_reg   <= e4_f_reg;
            e5_rho_reg <= e4_rho_reg;
            e5_ux_reg  <= e4_ux_reg;
            e5_uy_reg  <= e4_uy_reg;
        end
    end

    // E6: relaxation product
    pops_t rel_next;
    pops_t e6_rel_reg, e6_f_reg;
    val_t  e6_ux_reg, e6_uy_reg;
    dens_t e6_rho_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIR; i++)
            rel_next[i] = fmul(MW'(relax_rate_reg),
                               sxm(e5_f_reg[i]) - sxm(e5_feq_reg[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E6])
        begin
            e6_rel_reg <= rel_next;
            e6_f_reg   <= e5_f_reg;
            e6_rho_reg <= e5_rho_reg;
            e6_ux_reg  <= e5_ux_reg;
            e6_uy_reg  <= e5_uy_reg;
        end
    end

    // OUT: output register
    pops_t out_next;
    pops_t o_pop_reg;
    val_t  o_ux_reg, o_uy_reg;
    dens_t o_rho_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIR; i++)
            out_next[i] = sat(sxs(e6_f_reg[i]) - sxs(e6_rel_reg[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            o_pop_reg <= out_next;
            o_rho_reg <= e6_rho_reg;
            o_ux_reg  <= e6_ux_reg;
            o_uy_reg  <= e6_uy_reg;
        end
    end

    assign out_pop_0    = o_pop_reg[0];
    assign out_pop_1    = o_pop_reg[1];
    assign out_pop_2    = o_pop_reg[2];
    assign out_pop_3    = o_pop_reg[3];
    assign out_pop_4    = o_pop_reg[4];
    assign out_pop_5    = o_pop_reg[5];
    assign out_pop_6    = o_pop_reg[6];
    assign out_pop_7    = o_pop_reg[7];
    assign out_pop_8    = o_pop_reg[8];
    assign node_density = o_rho_reg;
    assign vel_x        = o_ux_reg;
    assign vel_y        = o_uy_reg;

    // an accepted node occupies the first stage in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[ST_L1])
        else $error("accepted node missing from first stage");

    // input is refused only with the first stage occupied and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> vld_reg[ST_L1] && vld_reg[ST_L2])
        else $error("input stalled with free first stages");

    // zero density forces zero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && node_density == '0 |-> vel_x == '0 && vel_y == '0)
        else $error("nonzero velocity at zero density");

endmodule
